FILE: rtl/lsfm_pkg.sv
// lsfm_pkg: shared constants, codes and lookup tables for the fm operator
// holds the quarter-wave log-sine and exponent tables used by lsfm_wave
// no dependencies
package lsfm_pkg;

   // log2 of the samples in one block, sets gain step rounding
   localparam int LOG2_BLOCK = 6;
   localparam int HALF_BLOCK = (1 << LOG2_BLOCK) >> 1;

   localparam int GAIN_W     = 10;
   localparam int STEP_W     = 12;
   localparam logic [GAIN_W-1:0] GAIN_MAX = 10'd512;

   localparam int IN_DATA_W  = 152;
   localparam int OUT_DATA_W = 32;

   // opcodes carried on tuser
   localparam logic OPCODE_BLOCK  = 1'b0;
   localparam logic OPCODE_SAMPLE = 1'b1;

   // operator modes
   localparam logic [1:0] MODE_PURE = 2'd0;
   localparam logic [1:0] MODE_MOD  = 2'd1;
   localparam logic [1:0] MODE_FB   = 2'd2;

   localparam logic [11:0] LOG_SIN_ROM [256] = '{
      12'd2137, 12'd1731, 12'd1543, 12'd1419, 12'd1326, 12'd1252, 12'd1190, 12'd1137,
      12'd1091, 12'd1050, 12'd1013, 12'd979, 12'd949, 12'd920, 12'd894, 12'd869,
      12'd846, 12'd825, 12'd804, 12'd785, 12'd767, 12'd749, 12'd732, 12'd717,
      12'd701, 12'd687, 12'd672, 12'd659, 12'd646, 12'd633, 12'd621, 12'd609,
      12'd598, 12'd587, 12'd576, 12'd566, 12'd556, 12'd546, 12'd536, 12'd527,
      12'd518, 12'd509, 12'd501, 12'd492, 12'd484, 12'd476, 12'd468, 12'd461,
      12'd453, 12'd446, 12'd439, 12'd432, 12'd425, 12'd418, 12'd411, 12'd405,
      12'd399, 12'd392, 12'd386, 12'd380, 12'd375, 12'd369, 12'd363, 12'd358,
      12'd352, 12'd347, 12'd341, 12'd336, 12'd331, 12'd326, 12'd321, 12'd316,
      12'd311, 12'd307, 12'd302, 12'd297, 12'd293, 12'd289, 12'd284, 12'd280,
      12'd276, 12'd271, 12'd267, 12'd263, 12'd259, 12'd255, 12'd251, 12'd248,
      12'd244, 12'd240, 12'd236, 12'd233, 12'd229, 12'd226, 12'd222, 12'd219,
      12'd215, 12'd212, 12'd209, 12'd205, 12'd202, 12'd199, 12'd196, 12'd193,
      12'd190, 12'd187, 12'd184, 12'd181, 12'd178, 12'd175, 12'd172, 12'd169,
      12'd167, 12'd164, 12'd161, 12'd159, 12'd156, 12'd153, 12'd151, 12'd148,
      12'd146, 12'd143, 12'd141, 12'd138, 12'd136, 12'd134, 12'd131, 12'd129,
      12'd127, 12'd125, 12'd122, 12'd120, 12'd118, 12'd116, 12'd114, 12'd112,
      12'd110, 12'd108, 12'd106, 12'd104, 12'd102, 12'd100, 12'd98, 12'd96,
      12'd94, 12'd92, 12'd91, 12'd89, 12'd87, 12'd85, 12'd83, 12'd82,
      12'd80, 12'd78, 12'd77, 12'd75, 12'd74, 12'd72, 12'd70, 12'd69,
      12'd67, 12'd66, 12'd64, 12'd63, 12'd62, 12'd60, 12'd59, 12'd57,
      12'd56, 12'd55, 12'd53, 12'd52, 12'd51, 12'd49, 12'd48, 12'd47,
      12'd46, 12'd45, 12'd43, 12'd42, 12'd41, 12'd40, 12'd39, 12'd38,
      12'd37, 12'd36, 12'd35, 12'd34, 12'd33, 12'd32, 12'd31, 12'd30,
      12'd29, 12'd28, 12'd27, 12'd26, 12'd25, 12'd24, 12'd23, 12'd23,
      12'd22, 12'd21, 12'd20, 12'd20, 12'd19, 12'd18, 12'd17, 12'd17,
      12'd16, 12'd15, 12'd15, 12'd14, 12'd13, 12'd13, 12'd12, 12'd12,
      12'd11, 12'd10, 12'd10, 12'd9, 12'd9, 12'd8, 12'd8, 12'd7,
      12'd7, 12'd7, 12'd6, 12'd6, 12'd5, 12'd5, 12'd5, 12'd4,
      12'd4, 12'd4, 12'd3, 12'd3, 12'd3, 12'd2, 12'd2, 12'd2,
      12'd2, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1,
      12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0
   };

   localparam logic [9:0] EXP_ROM [256] = '{
      10'd0, 10'd3, 10'd6, 10'd8, 10'd11, 10'd14, 10'd17, 10'd20,
      10'd22, 10'd25, 10'd28, 10'd31, 10'd34, 10'd37, 10'd40, 10'd42,
      10'd45, 10'd48, 10'd51, 10'd54, 10'd57, 10'd60, 10'd63, 10'd66,
      10'd69, 10'd72, 10'd75, 10'd78, 10'd81, 10'd84, 10'd87, 10'd90,
      10'd93, 10'd96, 10'd99, 10'd102, 10'd105, 10'd108, 10'd111, 10'd114,
      10'd117, 10'd120, 10'd123, 10'd126, 10'd130, 10'd133, 10'd136, 10'd139,
      10'd142, 10'd145, 10'd148, 10'd152, 10'd155, 10'd158, 10'd161, 10'd164,
      10'd168, 10'd171, 10'd174, 10'd177, 10'd181, 10'd184, 10'd187, 10'd190,
      10'd194, 10'd197, 10'd200, 10'd204, 10'd207, 10'd210, 10'd214, 10'd217,
      10'd220, 10'd224, 10'd227, 10'd231, 10'd234, 10'd237, 10'd241, 10'd244,
      10'd248, 10'd251, 10'd255, 10'd258, 10'd262, 10'd265, 10'd268, 10'd272,
      10'd276, 10'd279, 10'd283, 10'd286, 10'd290, 10'd293, 10'd297, 10'd300,
      10'd304, 10'd308, 10'd311, 10'd315, 10'd318, 10'd322, 10'd326, 10'd329,
      10'd333, 10'd337, 10'd340, 10'd344, 10'd348, 10'd352, 10'd355, 10'd359,
      10'd363, 10'd367, 10'd370, 10'd374, 10'd378, 10'd382, 10'd385, 10'd389,
      10'd393, 10'd397, 10'd401, 10'd405, 10'd409, 10'd412, 10'd416, 10'd420,
      10'd424, 10'd428, 10'd432, 10'd436, 10'd440, 10'd444, 10'd448, 10'd452,
      10'd456, 10'd460, 10'd464, 10'd468, 10'd472, 10'd476, 10'd480, 10'd484,
      10'd488, 10'd492, 10'd496, 10'd501, 10'd505, 10'd509, 10'd513, 10'd517,
      10'd521, 10'd526, 10'd530, 10'd534, 10'd538, 10'd542, 10'd547, 10'd551,
      10'd555, 10'd560, 10'd564, 10'd568, 10'd572, 10'd577, 10'd581, 10'd585,
      10'd590, 10'd594, 10'd599, 10'd603, 10'd607, 10'd612, 10'd616, 10'd621,
      10'd625, 10'd630, 10'd634, 10'd639, 10'd643, 10'd648, 10'd652, 10'd657,
      10'd661, 10'd666, 10'd670, 10'd675, 10'd680, 10'd684, 10'd689, 10'd693,
      10'd698, 10'd703, 10'd708, 10'd712, 10'd717, 10'd722, 10'd726, 10'd731,
      10'd736, 10'd741, 10'd745, 10'd750, 10'd755, 10'd760, 10'd765, 10'd770,
      10'd774, 10'd779, 10'd784, 10'd789, 10'd794, 10'd799, 10'd804, 10'd809,
      10'd814, 10'd819, 10'd824, 10'd829, 10'd834, 10'd839, 10'd844, 10'd849,
      10'd854, 10'd859, 10'd864, 10'd869, 10'd874, 10'd880, 10'd885, 10'd890,
      10'd895, 10'd900, 10'd906, 10'd911, 10'd916, 10'd921, 10'd927, 10'd932,
      10'd937, 10'd942, 10'd948, 10'd953, 10'd959, 10'd964, 10'd969, 10'd975,
      10'd980, 10'd986, 10'd991, 10'd996, 10'd1002, 10'd1007, 10'd1013, 10'd1018
   };

endpackage

FILE: rtl/log_sin_fm_operator.sv
// log_sin_fm_operator: fm operator sample generator, top level
// a sample item passes the input and result registers before rsp_tvalid rises
// throughput: one item per cycle unless rsp stalls; the feedback pair is registered
// reset: synchronous, active high; clears phase, gain, mode, feedback pair,
//   feedback shift and both valid flags
// depends on lsfm_pkg and lsfm_wave
module log_sin_fm_operator (
   input  logic                             clock,
   input  logic                             reset,
   // request side
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // phase_start[31:0], freq_step[63:32], gain_start[73:64], gain_end[83:74],
   // mode[85:84], add_enable[86], modulation[118:87], add_value[150:119], pad[151]
   input  logic [lsfm_pkg::IN_DATA_W-1:0]   req_tdata,
   // opcode[0]
   input  logic                             req_tuser,
   // response side
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // sample[31:0]
   output logic [lsfm_pkg::OUT_DATA_W-1:0]  rsp_tdata,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [3:0]                       csr_wr_data
);
   import lsfm_pkg::*;

   // ---------------------------------------------------------------- input register
   logic                  in_valid_ff;
   logic                  in_opcode_ff;
   logic [IN_DATA_W-1:0]  in_data_ff;
   logic                  advance;

   // the input register moves on whenever the result register is free or drains
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_opcode_ff <= req_tuser;
         in_data_ff   <= req_tdata;
      end
   end

   // unpacked fields of the registered item
   logic [31:0]       f_phase_start;
   logic [31:0]       f_freq_step;
   logic [GAIN_W-1:0] f_gain_start;
   logic [GAIN_W-1:0] f_gain_end;
   logic [1:0]        f_mode;
   logic              f_add_enable;
   logic [31:0]       f_modulation;
   logic [31:0]       f_add_value;

   assign f_phase_start = in_data_ff[31:0];
   assign f_freq_step   = in_data_ff[63:32];
   assign f_gain_start  = in_data_ff[73:64];
   assign f_gain_end    = in_data_ff[83:74];
   assign f_mode        = in_data_ff[85:84];
   assign f_add_enable  = in_data_ff[86];
   assign f_modulation  = in_data_ff[118:87];
   assign f_add_value   = in_data_ff[150:119];

   // ---------------------------------------------------------------- operator state
   logic [3:0]        fb_shift_ff;
   logic [31:0]       phase_acc_ff,  phase_acc_in;
   logic [31:0]       phase_incr_ff, phase_incr_in;
   logic [GAIN_W-1:0] gain_now_ff,   gain_now_in;
   logic [STEP_W-1:0] gain_step_ff,  gain_step_in;
   logic [1:0]        op_mode_ff,    op_mode_in;
   logic              adding_ff,     adding_in;
   logic [31:0]       fb_older_ff,   fb_older_in;
   logic [31:0]       fb_newer_ff,   fb_newer_in;

   // item in the input register is consumed this cycle
   logic fire;
   logic is_sample;
   assign fire      = in_valid_ff && advance;
   assign is_sample = (in_opcode_ff == OPCODE_SAMPLE);

   // block start: clamp the gains, rounded floor step per sample
   logic [GAIN_W-1:0]        g_start_clamped;
   logic [GAIN_W-1:0]        g_end_clamped;
   logic signed [STEP_W-1:0] gain_diff;

   assign g_start_clamped = (f_gain_start > GAIN_MAX) ? GAIN_MAX : f_gain_start;
   assign g_end_clamped   = (f_gain_end   > GAIN_MAX) ? GAIN_MAX : f_gain_end;
   assign gain_diff = $signed({2'b00, g_end_clamped}) - $signed({2'b00, g_start_clamped})
                      + $signed(STEP_W'(HALF_BLOCK));

   // sample: step the gain and hold it in 0..512
   logic signed [STEP_W:0] gain_sum;
   logic [GAIN_W-1:0]      gain_next;

   assign gain_sum = $signed({3'b000, gain_now_ff})
                     + $signed({gain_step_ff[STEP_W-1], gain_step_ff});

   always_comb begin
      if (gain_sum < 0) begin
         gain_next = '0;
      end else if (gain_sum > $signed({3'b000, GAIN_MAX})) begin
         gain_next = GAIN_MAX;
      end else begin
         gain_next = gain_sum[GAIN_W-1:0];
      end
   end

   // feedback term: average of the last two outputs, floor shift
   logic signed [32:0] fb_sum;
   logic signed [32:0] fb_scaled;
   logic [4:0]         fb_amount;

   assign fb_sum    = $signed({fb_older_ff[31], fb_older_ff})
                      + $signed({fb_newer_ff[31], fb_newer_ff});
   assign fb_amount = {1'b0, fb_shift_ff} + 5'd1;
   assign fb_scaled = fb_sum >>> fb_amount;

   // phase index by mode; mode three acts as pure
   logic [31:0] idx_full;

   always_comb begin
      case (op_mode_ff)
         MODE_MOD: idx_full = phase_acc_ff + f_modulation;
         MODE_FB:  idx_full = phase_acc_ff + fb_scaled[31:0];
         default:  idx_full = phase_acc_ff;
      endcase
   end

   logic [31:0] wave_bits;

   lsfm_wave u_wave (
      .phase_index (idx_full[23:14]),
      .env         (gain_next),
      .wave_bits   (wave_bits)
   );

   // next state
   always_comb begin
      phase_acc_in  = phase_acc_ff;
      phase_incr_in = phase_incr_ff;
      gain_now_in   = gain_now_ff;
      gain_step_in  = gain_step_ff;
      op_mode_in    = op_mode_ff;
      adding_in     = adding_ff;
      fb_older_in   = fb_older_ff;
      fb_newer_in   = fb_newer_ff;
      if (fire) begin
         if (is_sample) begin
            gain_now_in  = gain_next;
            phase_acc_in = phase_acc_ff + phase_incr_ff;
            if (op_mode_ff == MODE_FB) begin
               fb_older_in = fb_newer_ff;
               fb_newer_in = wave_bits;
            end
         end else begin
            phase_acc_in  = f_phase_start;
            phase_incr_in = f_freq_step;
            gain_now_in   = g_start_clamped;
            gain_step_in  = gain_diff >>> LOG2_BLOCK;
            op_mode_in    = f_mode;
            adding_in     = f_add_enable;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_shift_ff   <= '0;
         phase_acc_ff  <= '0;
         phase_incr_ff <= '0;
         gain_now_ff   <= '0;
         gain_step_ff  <= '0;
         op_mode_ff    <= MODE_PURE;
         adding_ff     <= 1'b0;
         fb_older_ff   <= '0;
         fb_newer_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            fb_shift_ff <= csr_wr_data;
         end
         phase_acc_ff  <= phase_acc_in;
         phase_incr_ff <= phase_incr_in;
         gain_now_ff   <= gain_now_in;
         gain_step_ff  <= gain_step_in;
         op_mode_ff    <= op_mode_in;
         adding_ff     <= adding_in;
         fb_older_ff   <= fb_older_in;
         fb_newer_ff   <= fb_newer_in;
      end
   end

   // ---------------------------------------------------------------- result register
   logic              out_valid_ff;
   logic [31:0]       out_data_ff;

   // block start items leave no result
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff && is_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && is_sample) begin
         out_data_ff <= adding_ff ? (wave_bits + f_add_value) : wave_bits;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: rtl/lsfm_wave.sv
// lsfm_wave: log-sine lookup, attenuation and exponent conversion
// turns a 10-bit phase index and an attenuation into the operator value << 14
// depends on lsfm_pkg for the two tables
module lsfm_wave (
   input  logic [9:0]                  phase_index,
   input  logic [lsfm_pkg::GAIN_W-1:0] env,
   output logic [31:0]                 wave_bits
);
   import lsfm_pkg::*;

   logic [7:0]  low;
   logic        neg;
   logic [12:0] att;
   logic [11:0] mag_full;
   logic [11:0] mag;
   logic [4:0]  att_shift;
   logic [12:0] wave_val;

   // mirror the second and fourth quarter, sign from the upper half
   assign neg       = phase_index[9];
   assign low       = phase_index[7:0] ^ {8{phase_index[8]}};
   assign att       = {1'b0, LOG_SIN_ROM[low]} + {env, 3'b000};
   assign mag_full  = {1'b0, 1'b1, EXP_ROM[~att[7:0]]} << 1;
   assign att_shift = att[12:8];
   assign mag       = mag_full >> att_shift;
   // one's-complement negative: -mag - 1
   assign wave_val  = neg ? ~{1'b0, mag} : {1'b0, mag};
   assign wave_bits = {{5{wave_val[12]}}, wave_val, 14'd0};

endmodule

FILE: rtl/lsfm_checker.sv
// lsfm_checker: port-level checks on the fm operator over time
// bound to log_sin_fm_operator; depends on nothing else
module lsfm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // nothing shows right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a fresh result comes only from a sample item taken at req earlier
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tuser, 2))
      else $error("result without a sample item");

   // with the result register empty the block always takes an item
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("backpressure with empty result register");

endmodule

bind log_sin_fm_operator lsfm_checker u_lsfm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: sim/log_sin_fm_operator_test.sv
// log_sin_fm_operator_test: self-checking bench for the fm operator sample generator
// drives block-start and sample items, predicts every sample and compares on rsp
// depends on lsfm_pkg and log_sin_fm_operator
`timescale 1ns / 100ps

module log_sin_fm_operator_test;
   import lsfm_pkg::*;

   // mode code with no package name, the block runs it as pure
   localparam logic [1:0] MODE_SPARE = 2'd3;
   // generous bound on the whole run, the slowest correct run is far below this
   localparam int CYCLE_LIMIT = 600000;
   // rsp goes valid after the input and result registers, leave a margin past that
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      logic        opcode;
      logic [31:0] phase_start;
      logic [31:0] freq_step;
      logic [9:0]  gain_start;
      logic [9:0]  gain_end;
      logic [1:0]  mode;
      logic        add_enable;
      logic [31:0] modulation;
      logic [31:0] add_value;
   } op_item_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [IN_DATA_W-1:0] req_tdata = '0;
   logic                 req_tuser = OPCODE_BLOCK;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;
   logic                 csr_wr_en = 1'b0;
   logic [3:0]           csr_wr_data = '0;

   log_sin_fm_operator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // items waiting for the driver, and samples waiting for rsp
   op_item_type pending_items[$];
   logic [31:0] expected_samples[$];
   op_item_type held_item;
   int          queued_count = 0;
   int          accepted_count = 0;
   int          mismatches = 0;
   int          cycle_count = 0;

   // idle percentages per side, changed between phases
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int send_gap = 0;
   int recv_stall = 0;

   // feedback shift per random phase, negative picks one at random
   int shift_plan[6] = '{15, 0, 7, -1, 1, -1};

   // operator state as the bench sees it
   logic [31:0] ph_accum = '0;
   logic [31:0] ph_step = '0;
   int          env_level = 0;
   int          env_slope = 0;
   logic [1:0]  cur_mode = MODE_PURE;
   logic        mix_bus = 1'b0;
   logic [31:0] fb_prev = '0;
   logic [31:0] fb_last = '0;
   int          fb_shift_copy = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int clamp_gain(input int g);
      if (g < 0) return 0;
      if (g > int'(GAIN_MAX)) return int'(GAIN_MAX);
      return g;
   endfunction

   // quarter-wave log-sine lookup, attenuation, then back through the exp table
   function automatic logic [31:0] wave_value(input logic [9:0] idx, input int env);
      logic [7:0] low;
      logic [7:0] exp_idx;
      int         att;
      int         mag;
      low = idx[7:0];
      // second and fourth quarter run the table backwards
      if (idx[8])
         low = ~low;
      att = int'(LOG_SIN_ROM[low]) + env * 8;
      exp_idx = ~att[7:0];
      mag = (1024 + int'(EXP_ROM[exp_idx])) << 1;
      mag = mag >> (att >> 8);
      // lower half wave: one's complement sign
      return idx[9] ? ~mag : mag;
   endfunction

   // applies one accepted item to the operator state, queues its sample if any
   task automatic advance_operator(input op_item_type it);
      int          g_from;
      int          g_to;
      logic [31:0] ph_index;
      longint      fb_sum;
      logic [31:0] y_bits;
      if (it.opcode == OPCODE_BLOCK) begin
         g_from = clamp_gain(int'(it.gain_start));
         g_to = clamp_gain(int'(it.gain_end));
         ph_accum = it.phase_start;
         ph_step = it.freq_step;
         env_level = g_from;
         // rounded slope, the arithmetic shift floors negative values
         env_slope = (g_to - g_from + HALF_BLOCK) >>> LOG2_BLOCK;
         cur_mode = it.mode;
         mix_bus = it.add_enable;
      end else begin
         env_level = clamp_gain(env_level + env_slope);
         case (cur_mode)
            MODE_MOD: begin
               ph_index = ph_accum + it.modulation;
            end
            MODE_FB: begin
               fb_sum = longint'($signed(fb_prev)) + longint'($signed(fb_last));
               fb_sum = fb_sum >>> (fb_shift_copy + 1);
               ph_index = ph_accum + fb_sum[31:0];
            end
            default: begin
               ph_index = ph_accum;
            end
         endcase
         y_bits = wave_value(ph_index[23:14], env_level) << 14;
         // feedback pair only moves on feedback samples
         if (cur_mode == MODE_FB) begin
            fb_prev = fb_last;
            fb_last = y_bits;
         end
         expected_samples.push_back(mix_bus ? y_bits + it.add_value : y_bits);
         ph_accum = ph_accum + ph_step;
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   // mostly short gaps, now and then a long one
   function automatic int draw_gap(input int pct);
      if ($urandom_range(0, 99) >= pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic op_item_type make_item(
      input logic op, input logic [31:0] ph, input logic [31:0] stp,
      input logic [9:0] g_from, input logic [9:0] g_to, input logic [1:0] md,
      input logic add, input logic [31:0] md_in, input logic [31:0] bus_in);
      op_item_type it;
      it.opcode = op;
      it.phase_start = ph;
      it.freq_step = stp;
      it.gain_start = g_from;
      it.gain_end = g_to;
      it.mode = md;
      it.add_enable = add;
      it.modulation = md_in;
      it.add_value = bus_in;
      return it;
   endfunction

   function automatic logic [9:0] rand_gain();
      // out of range now and then to hit the clamp
      if ($urandom_range(0, 9) == 0)
         return 10'($urandom_range(513, 1023));
      return 10'($urandom_range(0, 512));
   endfunction

   function automatic op_item_type rand_block();
      op_item_type it;
      int          r;
      logic [31:0] stp;
      r = $urandom_range(0, 3);
      case (r)
         0: stp = $urandom;
         1: stp = $urandom_range(0, 32'h0010_0000);
         2: stp = -$urandom_range(0, 32'h0010_0000);
         default: stp = 32'h0000_4000 * $urandom_range(0, 1023);
      endcase
      r = $urandom_range(0, 9);
      it = make_item(OPCODE_BLOCK, $urandom, stp, rand_gain(), rand_gain(),
                     (r < 2) ? MODE_PURE : (r < 4) ? MODE_MOD : (r < 9) ? MODE_FB
                                                                         : MODE_SPARE,
                     1'($urandom_range(0, 1)), $urandom, $urandom);
      return it;
   endfunction

   function automatic op_item_type rand_sample();
      op_item_type it;
      logic [31:0] md_in;
      // small modulation keeps the index near the carrier, full range elsewhere
      if ($urandom_range(0, 1) == 0)
         md_in = $urandom;
      else
         md_in = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      it = make_item(OPCODE_SAMPLE, $urandom, $urandom, 10'($urandom), 10'($urandom),
                     2'($urandom), 1'($urandom), md_in, $urandom);
      return it;
   endfunction

   task automatic queue_item(input op_item_type it);
      pending_items.push_back(it);
      queued_count++;
   endtask

   // well-formed blocks with random content, plus stray items
   task automatic queue_random(input int n_items);
      int n;
      int len;
      n = 0;
      while (n < n_items) begin
         if ($urandom_range(0, 9) < 8) begin
            queue_item(rand_block());
            // a full ramp now and then, short blocks otherwise
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 70)
                                              : $urandom_range(1, 20);
            repeat (len) queue_item(rand_sample());
            n += len + 1;
         end else begin
            queue_item(($urandom_range(0, 1) == 0) ? rand_block() : rand_sample());
            n++;
         end
      end
   endtask

   // all queued items taken and every sample back, then let the pipe drain
   task automatic wait_idle();
      while (accepted_count != queued_count || expected_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_fb_shift(input logic [3:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      fb_shift_copy = int'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         // item taken at this edge goes through the predictor
         if (req_tvalid && req_tready) begin
            advance_operator(held_item);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               held_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               // add_value, modulation, add_enable, mode, gains, step, phase
               req_tdata <= {1'b0, held_item.add_value, held_item.modulation,
                             held_item.add_enable, held_item.mode, held_item.gain_end,
                             held_item.gain_start, held_item.freq_step,
                             held_item.phase_start};
               req_tuser <= held_item.opcode;
               send_gap = draw_gap(send_idle_pct);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: sample error, expected nothing, got %h", $time, rsp_tdata);
               mismatches++;
            end else if (rsp_tdata !== expected_samples[0]) begin
               $display("%0t: sample error, expected %h, got %h", $time,
                        expected_samples[0], rsp_tdata);
               mismatches++;
               void'(expected_samples.pop_front());
            end else begin
               void'(expected_samples.pop_front());
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall = draw_gap(recv_idle_pct);
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_fb_shift(4'd0);

      send_idle_pct = 30;
      recv_idle_pct = 30;
      // sample straight out of reset: pure mode, phase and gain at zero
      queue_item(make_item(OPCODE_SAMPLE, '1, '1, '1, '1, '1, 1'b1, '1, '1));
      // quarter-turn steps: every quadrant at both table ends, full volume
      queue_item(make_item(OPCODE_BLOCK, 32'h0, 32'h0040_0000, 10'd0, 10'd0,
                           MODE_PURE, 1'b0, '0, '0));
      repeat (4) queue_item(make_item(OPCODE_SAMPLE, '0, '0, '0, '0, '0, 1'b0, '0, '0));
      // start gain above range, spare mode runs as pure, bus sums at the extremes
      queue_item(make_item(OPCODE_BLOCK, 32'hFFFF_C000, 32'h8000_0000, 10'd1023, 10'd0,
                           MODE_SPARE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_item(make_item(OPCODE_SAMPLE, '0, '0, '0, '0, '0, 1'b0, '0, 32'h7FFF_FFFF));
      queue_item(make_item(OPCODE_SAMPLE, '0, '0, '0, '0, '0, 1'b0, '0, 32'h8000_0000));
      // end gain above range, modulation at its extremes
      queue_item(make_item(OPCODE_BLOCK, 32'h7FFF_FFFF, 32'h0000_4000, 10'd0, 10'd700,
                           MODE_MOD, 1'b0, '0, '0));
      queue_item(make_item(OPCODE_SAMPLE, '0, '0, '0, '0, '0, 1'b0, 32'h8000_0000, '0));
      queue_item(make_item(OPCODE_SAMPLE, '0, '0, '0, '0, '0, 1'b0, 32'h7FFF_FFFF, '0));
      queue_item(make_item(OPCODE_SAMPLE, '0, '0, '0, '0, '0, 1'b0, 32'hFFFF_FFFF, '0));
      // feedback from a cleared pair, then building up
      queue_item(make_item(OPCODE_BLOCK, 32'h0, 32'h0010_0000, 10'd0, 10'd0,
                           MODE_FB, 1'b1, '0, '0));
      queue_item(make_item(OPCODE_SAMPLE, '0, '0, '0, '0, '0, 1'b0, '0, 32'h0));
      queue_item(make_item(OPCODE_SAMPLE, '0, '0, '0, '0, '0, 1'b0, '0, 32'hFFFF_FFFF));
      queue_item(make_item(OPCODE_SAMPLE, '0, '0, '0, '0, '0, 1'b0, '0, 32'h0));
      queue_item(make_item(OPCODE_SAMPLE, '0, '0, '0, '0, '0, 1'b0, '0, 32'h1234_5678));
      // full attenuation, output down to zero
      queue_item(make_item(OPCODE_BLOCK, 32'h0010_0000, 32'h0, 10'd512, 10'd512,
                           MODE_PURE, 1'b0, '0, '0));
      queue_item(make_item(OPCODE_SAMPLE, '0, '0, '0, '0, '0, 1'b0, '0, '0));
      wait_idle();

      // random phases under several feedback shifts, extremes included
      foreach (shift_plan[k]) begin
         write_fb_shift((shift_plan[k] < 0) ? 4'($urandom) : 4'(shift_plan[k]));
         // one phase with no idling at all, the rest mixed
         send_idle_pct = (k == 1) ? 0 : $urandom_range(10, 50);
         recv_idle_pct = (k == 1) ? 0 : $urandom_range(10, 50);
         queue_random(250);
         wait_idle();
      end

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: sim.f
rtl/lsfm_pkg.sv
rtl/lsfm_wave.sv
rtl/log_sin_fm_operator.sv
rtl/lsfm_checker.sv
sim/log_sin_fm_operator_test.sv
